// File: src/tld_pkg.sv
// Shared types, character codes and the backslash escape table for the
// terminal line editor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam logic [6:0] CH_EOT  = 7'o004;
    localparam logic [6:0] CH_NL   = 7'o012;
    localparam logic [6:0] CH_CR   = 7'o015;
    localparam logic [6:0] CH_XON  = 7'o021;
    localparam logic [6:0] CH_XOFF = 7'o023;
    localparam logic [6:0] CH_BSL  = 7'o134;
    localparam logic [6:0] CH_UC_A = 7'o101;
    localparam logic [6:0] CH_UC_Z = 7'o132;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ERASE   = 3'd0,
        REG_KILL    = 3'd1,
        REG_INTR    = 3'd2,
        REG_QUIT    = 3'd3,
        REG_RAW     = 3'd4,
        REG_LCASE   = 3'd5,
        REG_CRNL    = 3'd6,
        REG_FLOW    = 3'd7
    } tld_reg_t;

    typedef enum logic [2:0] {
        EV_LINE   = 3'd0,
        EV_EOF    = 3'd1,
        EV_INT    = 3'd2,
        EV_QUIT   = 3'd3,
        EV_STOP   = 3'd4,
        EV_RESUME = 3'd5
    } tld_event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EDIT,
        ST_EMIT,
        ST_FETCH,
        ST_DRAIN
    } tld_state_t;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic look;     // read data holds the last stored char
        logic edit;     // read data holds the char before it; commit edit
        logic fetch;    // start reading the line from entry 0
        logic pop;      // line byte taken by the sink
        logic drain;    // result bytes come from the line memory
    } tld_cmd_t;

    typedef struct packed {
        logic single;   // incoming char gives exactly one result
        logic term;     // edit finished the line
        logic eof;      // finished line is empty
        logic last;     // current line byte is the final one
    } tld_status_t;

    // backslash escape map, zero means no escape
    function automatic logic [6:0] esc_map(input logic [6:0] c);
        logic [6:0] m;
        m = 7'd0;
        case (c)
            7'o004:  m = 7'o004;
            7'o041:  m = 7'o174;   // ! -> |
            7'o043:  m = 7'o043;   // #
            7'o047:  m = 7'o140;   // ' -> `
            7'o050:  m = 7'o173;   // ( -> {
            7'o051:  m = 7'o175;   // ) -> }
            7'o100:  m = 7'o100;   // @
            7'o136:  m = 7'o176;   // ^ -> ~
            default: begin
                if (c >= 7'o141 && c <= 7'o172) begin
                    m = c - 7'o040;    // lower to upper
                end
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: src/tty_line_discipline_editor.sv
// Top level of the terminal line editor: sequencer plus datapath.
// Depends on tld_pkg, tld_ctrl and tld_dp.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received character per input beat and works on one character at
// a time. A character that gives a single result (raw mode, interrupt, quit,
// XOFF, XON) is taken in idle and its result beat is offered the next cycle.
// An edited character passes accept, look and edit, the two look-back reads of
// the single-port line memory being issued in accept and look; a finished line
// then passes a fetch state that starts the memory read, and its bytes go out
// at one beat per cycle while the sink does not stall. An empty finished line
// gives one end-of-file beat. Mode registers are written through the cfg port
// by the user only while idle; the block itself does not enforce this.
module tty_line_discipline_editor #(
    parameter int LINE_BYTES = tld_pkg::LINE_BYTES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [6:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_received_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_res,
    output logic [6:0]      m_data_char,
    output logic            m_last_of_run
);

    tld_pkg::tld_cmd_t    cmd;
    tld_pkg::tld_status_t status;

    tld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tld_dp #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_received_char (s_received_char),
        .cmd             (cmd),
        .status          (status),
        .m_event_res     (m_event_res),
        .m_data_char     (m_data_char),
        .m_last_of_run   (m_last_of_run)
    );

    // one character in flight: never take input while a result is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input taken while a result beat is pending");

    // the final beat of a run returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run |=> s_ready && !m_valid)
        else $error("block not idle after final result beat");

    // a non-final beat is always a line byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_event_res == tld_pkg::EV_LINE)
        else $error("non-final beat carries a non-line event");

    // only line bytes carry character data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != tld_pkg::EV_LINE |-> m_data_char == 7'd0)
        else $error("event beat carries character data");

endmodule

`default_nettype wire

// File: src/tld_ctrl.sv
// Sequencer for the terminal line editor: accept, look-back reads, edit,
// single results and line drain. Depends on tld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tld_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire tld_pkg::tld_status_t status,
    output tld_pkg::tld_cmd_t         cmd
);

    tld_pkg::tld_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tld_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tld_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.single ? tld_pkg::ST_EMIT : tld_pkg::ST_LOOK;
                end
            end
            tld_pkg::ST_LOOK: state_next = tld_pkg::ST_EDIT;
            tld_pkg::ST_EDIT: begin
                if (!status.term) begin
                    state_next = tld_pkg::ST_IDLE;
                end else if (status.eof) begin
                    state_next = tld_pkg::ST_EMIT;
                end else begin
                    state_next = tld_pkg::ST_FETCH;
                end
            end
            tld_pkg::ST_EMIT: begin
                if (m_ready) begin
                    state_next = tld_pkg::ST_IDLE;
                end
            end
            tld_pkg::ST_FETCH: state_next = tld_pkg::ST_DRAIN;
            tld_pkg::ST_DRAIN: begin
                if (m_ready && status.last) begin
                    state_next = tld_pkg::ST_IDLE;
                end
            end
            default: state_next = tld_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == tld_pkg::ST_IDLE);
        m_valid    = (state_reg == tld_pkg::ST_EMIT) || (state_reg == tld_pkg::ST_DRAIN);
        cmd.accept = (state_reg == tld_pkg::ST_IDLE) && s_valid;
        cmd.look   = (state_reg == tld_pkg::ST_LOOK);
        cmd.edit   = (state_reg == tld_pkg::ST_EDIT);
        cmd.fetch  = (state_reg == tld_pkg::ST_FETCH);
        cmd.pop    = (state_reg == tld_pkg::ST_DRAIN) && m_ready;
        cmd.drain  = (state_reg == tld_pkg::ST_DRAIN);
    end

endmodule

`default_nettype wire

// File: src/tld_dp.sv
// Datapath of the terminal line editor: mode registers, input mapping,
// line memory, fill count and edit logic. Depends on tld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tld_dp #(
    parameter int LINE_BYTES = tld_pkg::LINE_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [6:0]           cfg_wr_data,
    input  wire logic [7:0]           s_received_char,
    input  wire tld_pkg::tld_cmd_t    cmd,
    output tld_pkg::tld_status_t      status,
    output logic [2:0]                m_event_res,
    output logic [6:0]                m_data_char,
    output logic                      m_last_of_run
);

    localparam int IW = $clog2(LINE_BYTES);
    localparam int FW = $clog2(LINE_BYTES + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(LINE_BYTES);

    // mode registers
    logic [6:0] erase_reg, kill_reg, intr_reg, quit_reg;
    logic       raw_reg, lcase_reg, crnl_reg, flow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_reg <= 7'd35;
            kill_reg  <= 7'd64;
            intr_reg  <= 7'd127;
            quit_reg  <= 7'd28;
            raw_reg   <= 1'b0;
            lcase_reg <= 1'b0;
            crnl_reg  <= 1'b1;
            flow_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (tld_pkg::tld_reg_t'(cfg_index))
                tld_pkg::REG_ERASE: erase_reg <= cfg_wr_data;
                tld_pkg::REG_KILL:  kill_reg  <= cfg_wr_data;
                tld_pkg::REG_INTR:  intr_reg  <= cfg_wr_data;
                tld_pkg::REG_QUIT:  quit_reg  <= cfg_wr_data;
                tld_pkg::REG_RAW:   raw_reg   <= cfg_wr_data[0];
                tld_pkg::REG_LCASE: lcase_reg <= cfg_wr_data[0];
                tld_pkg::REG_CRNL:  crnl_reg  <= cfg_wr_data[0];
                tld_pkg::REG_FLOW:  flow_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // input mapping
    logic [6:0] c_mask, c_map, c_fold;
    logic       is_int, is_quit, is_xoff, is_xon;
    tld_pkg::tld_event_t ev_in;

    always_comb begin
        c_mask  = s_received_char[6:0];
        c_map   = (crnl_reg && c_mask == tld_pkg::CH_CR) ? tld_pkg::CH_NL : c_mask;
        is_int  = !raw_reg && c_map == intr_reg;
        is_quit = !raw_reg && c_map == quit_reg;
        is_xoff = !raw_reg && flow_reg && c_map == tld_pkg::CH_XOFF;
        is_xon  = !raw_reg && flow_reg && c_map == tld_pkg::CH_XON;
        c_fold  = c_map;
        if (lcase_reg && c_map >= tld_pkg::CH_UC_A && c_map <= tld_pkg::CH_UC_Z) begin
            c_fold = c_map + 7'o040;
        end
        if (is_int) begin
            ev_in = tld_pkg::EV_INT;
        end else if (is_quit) begin
            ev_in = tld_pkg::EV_QUIT;
        end else if (is_xoff) begin
            ev_in = tld_pkg::EV_STOP;
        end else if (is_xon) begin
            ev_in = tld_pkg::EV_RESUME;
        end else begin
            ev_in = tld_pkg::EV_LINE;
        end
    end

    // item registers
    logic [6:0]          c_reg, c_next;
    logic [6:0]          emit_data_reg, emit_data_next;
    tld_pkg::tld_event_t ev_reg, ev_next;
    logic                prev_bs_reg, prev_bs_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [IW-1:0]       idx_reg, idx_next;

    // line memory
    logic [6:0]    line_mem [LINE_BYTES];
    logic [6:0]    rdata_reg;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [6:0]    wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // edit logic, valid in the edit cycle
    logic [6:0]    esc_val, c_store;
    logic          esc_hit, pp_bs, do_store, nl_or_eot;
    logic [FW-1:0] fill_esc, fill_edit, fill_m1, fill_m2;
    logic          last_byte;

    always_comb begin
        fill_m1   = fill_reg - FW'(1);
        fill_m2   = fill_reg - FW'(2);
        esc_val   = tld_pkg::esc_map(c_reg);
        esc_hit   = prev_bs_reg && esc_val != 7'd0 && (esc_val == c_reg || lcase_reg);
        pp_bs     = (fill_reg >= FW'(2)) && rdata_reg == tld_pkg::CH_BSL;
        fill_esc  = esc_hit ? fill_m1 : fill_reg;
        c_store   = (esc_hit && !pp_bs) ? esc_val : c_reg;
        nl_or_eot = c_reg == tld_pkg::CH_NL || c_reg == tld_pkg::CH_EOT;
        do_store  = 1'b0;
        if (!prev_bs_reg && c_reg == erase_reg) begin
            fill_edit = (fill_reg != '0) ? fill_m1 : fill_reg;
        end else if (!prev_bs_reg && c_reg == kill_reg) begin
            fill_edit = '0;
        end else if (!prev_bs_reg && c_reg == tld_pkg::CH_EOT) begin
            fill_edit = fill_reg;
        end else begin
            do_store  = 1'b1;
            fill_edit = fill_esc + FW'(1);
        end
        last_byte = (FW'(idx_reg) + FW'(1)) == fill_reg;

        status.single = raw_reg || is_int || is_quit || is_xoff || is_xon;
        status.term   = nl_or_eot || (do_store && fill_edit == FILL_FULL);
        status.eof    = fill_edit == '0;
        status.last   = last_byte;

        wr_en   = cmd.edit && do_store;
        wr_addr = fill_esc[IW-1:0];
        wr_data = c_store;
    end

    // register updates and memory read port
    always_comb begin
        c_next         = c_reg;
        emit_data_next = emit_data_reg;
        ev_next        = ev_reg;
        prev_bs_next   = prev_bs_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        rd_en          = 1'b0;
        rd_addr        = fill_m1[IW-1:0];
        if (cmd.accept) begin
            c_next         = c_fold;
            ev_next        = ev_in;
            emit_data_next = raw_reg ? c_fold : 7'd0;
            rd_en          = 1'b1;
            if (is_int || is_quit) begin
                fill_next = '0;
            end
        end
        if (cmd.look) begin
            prev_bs_next = (fill_reg != '0) && rdata_reg == tld_pkg::CH_BSL;
            rd_en        = 1'b1;
            rd_addr      = fill_m2[IW-1:0];
        end
        if (cmd.edit) begin
            fill_next      = fill_edit;
            emit_data_next = 7'd0;
            ev_next        = status.eof ? tld_pkg::EV_EOF : tld_pkg::EV_LINE;
        end
        if (cmd.fetch) begin
            idx_next = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
        end
        if (cmd.pop) begin
            if (last_byte) begin
                fill_next = '0;
            end else begin
                idx_next = idx_reg + IW'(1);
                rd_en    = 1'b1;
                rd_addr  = idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
        c_reg         <= c_next;
        emit_data_reg <= emit_data_next;
        ev_reg        <= ev_next;
        prev_bs_reg   <= prev_bs_next;
        idx_reg       <= idx_next;
    end

    assign m_event_res   = ev_reg;
    assign m_data_char   = cmd.drain ? rdata_reg : emit_data_reg;
    assign m_last_of_run = cmd.drain ? last_byte : 1'b1;

endmodule

`default_nettype wire

// File: tb/sv/tty_line_discipline_editor_test.sv
`timescale 1ns / 1ps

// Self-checking bench for tty_line_discipline_editor: a directed table, then random
// line traffic under several mode settings, scored beat by beat against a line-edit
// predictor. Depends on tld_pkg and the editor RTL.
module tty_line_discipline_editor_test;

    localparam int LINE_BYTES     = tld_pkg::LINE_BYTES_DEF;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEMS_PER_MODE = 55;
    localparam int MODE_SETS      = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        tld_pkg::tld_event_t ev;
        logic [6:0]          data;
        logic                last;
    } line_result_t;

    typedef enum {ROW_CHAR, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        tld_pkg::tld_reg_t   idx;
        logic [7:0]          value;
        bit                  known;
        tld_pkg::tld_event_t ev;
        logic [6:0]          data;
    } plan_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    tld_pkg::tld_reg_t cfg_index = tld_pkg::REG_ERASE;
    logic [6:0]        cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_received_char = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_event_res;
    logic [6:0]        m_data_char;
    logic              m_last_of_run;

    // predictor copy of the mode registers and line state
    logic [6:0] erase_ch = 7'd35;
    logic [6:0] kill_ch = 7'd64;
    logic [6:0] intr_ch = 7'd127;
    logic [6:0] quit_ch = 7'd28;
    bit         raw_on = 1'b0;
    bit         lcase_on = 1'b0;
    bit         crnl_on = 1'b1;
    bit         flow_on = 1'b0;
    logic [6:0] line_buf [LINE_BYTES];
    int         line_len = 0;
    bit         out_stopped = 1'b0;

    line_result_t results_due[$];
    line_result_t step_out[$];
    plan_row_t    plan[$];
    line_result_t head;

    int fail_count = 0;
    int cycle_count = 0;
    int counted_items = 0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_step = 0;
    logic [7:0] stall_pat = 8'hFF;

    tty_line_discipline_editor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_received_char (s_received_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_data_char     (m_data_char),
        .m_last_of_run   (m_last_of_run)
    );

    always #2 aclk = ~aclk;

    function automatic logic [6:0] escaped_as(input logic [6:0] c);
        case (c)
            tld_pkg::CH_EOT: return tld_pkg::CH_EOT;
            7'd33:   return 7'd124;
            7'd35:   return 7'd35;
            7'd39:   return 7'd96;
            7'd40:   return 7'd123;
            7'd41:   return 7'd125;
            7'd64:   return 7'd64;
            7'd94:   return 7'd126;
            default: return (c >= 7'd97 && c <= 7'd122) ? c - 7'd32 : 7'd0;
        endcase
    endfunction

    function automatic void emit(input tld_pkg::tld_event_t ev, input logic [6:0] d,
                                 input logic last);
        line_result_t r;
        r.ev = ev;
        r.data = d;
        r.last = last;
        step_out.push_back(r);
    endfunction

    // Edits one received character into the line; result beats go to step_out.
    function automatic void edit_char(input logic [7:0] rx);
        logic [6:0] c;
        logic [6:0] m;
        bit term;
        bit store;
        bit prev_bs;
        c = rx[6:0];
        step_out.delete();
        if (c == tld_pkg::CH_CR && crnl_on) c = tld_pkg::CH_NL;
        if (!raw_on) begin
            if (c == intr_ch || c == quit_ch) begin
                line_len = 0;
                emit(c == intr_ch ? tld_pkg::EV_INT : tld_pkg::EV_QUIT, 7'd0, 1'b1);
                return;
            end
            if (flow_on && (c == tld_pkg::CH_XOFF || c == tld_pkg::CH_XON)) begin
                out_stopped = (c == tld_pkg::CH_XOFF);
                emit(out_stopped ? tld_pkg::EV_STOP : tld_pkg::EV_RESUME, 7'd0, 1'b1);
                return;
            end
        end
        if (lcase_on && c >= tld_pkg::CH_UC_A && c <= tld_pkg::CH_UC_Z) c = c + 7'd32;
        if (raw_on) begin
            emit(tld_pkg::EV_LINE, c, 1'b1);
            return;
        end
        term = (c == tld_pkg::CH_NL || c == tld_pkg::CH_EOT);
        prev_bs = line_len > 0 && line_buf[line_len - 1] == tld_pkg::CH_BSL;
        store = 1'b1;
        if (!prev_bs) begin
            if (c == erase_ch) begin
                if (line_len > 0) line_len--;
                store = 1'b0;
            end else if (c == kill_ch) begin
                line_len = 0;
                store = 1'b0;
            end else if (c == tld_pkg::CH_EOT) begin
                store = 1'b0;
            end
        end else begin
            m = escaped_as(c);
            if (m != 7'd0 && (m == c || lcase_on)) begin
                // a doubled backslash keeps the character as typed
                if (!(line_len >= 2 && line_buf[line_len - 2] == tld_pkg::CH_BSL)) c = m;
                line_len--;
            end
        end
        if (store) begin
            line_buf[line_len] = c;
            line_len++;
            if (line_len == LINE_BYTES) term = 1'b1;
        end
        if (!term) return;
        if (line_len == 0) emit(tld_pkg::EV_EOF, 7'd0, 1'b1);
        for (int k = 0; k < line_len; k++) begin
            emit(tld_pkg::EV_LINE, line_buf[k], k == line_len - 1);
        end
        line_len = 0;
    endfunction

    function automatic void plan_char(input logic [7:0] v);
        plan_row_t r;
        r.kind = ROW_CHAR;
        r.idx = tld_pkg::REG_ERASE;
        r.value = v;
        r.known = 1'b0;
        r.ev = tld_pkg::EV_LINE;
        r.data = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_known(input logic [7:0] v, input tld_pkg::tld_event_t ev,
                                       input logic [6:0] d);
        plan_row_t r;
        r.kind = ROW_CHAR;
        r.idx = tld_pkg::REG_ERASE;
        r.value = v;
        r.known = 1'b1;
        r.ev = ev;
        r.data = d;
        plan.push_back(r);
    endfunction

    function automatic void plan_reg(input tld_pkg::tld_reg_t idx, input logic [6:0] v);
        plan_row_t r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.value = {1'b0, v};
        r.known = 1'b0;
        r.ev = tld_pkg::EV_LINE;
        r.data = '0;
        plan.push_back(r);
    endfunction

    // Offers one beat; a burst keeps valid high across calls made in the same step.
    task automatic send_char(input logic [7:0] ch, input bit known = 1'b0,
                             input tld_pkg::tld_event_t ev = tld_pkg::EV_LINE,
                             input logic [6:0] data = '0);
        int len_was;
        line_result_t r;
        repeat (gap_left) @(posedge aclk);
        gap_left = 0;
        if (burst_left == 0) burst_left = $urandom_range(1, 20);
        s_valid <= 1'b1;
        s_received_char <= ch;
        do @(posedge aclk); while (!s_ready);
        len_was = line_len;
        edit_char(ch);
        if (known) begin
            r.ev = ev;
            r.data = data;
            r.last = 1'b1;
            results_due.push_back(r);
        end else begin
            foreach (step_out[i]) results_due.push_back(step_out[i]);
        end
        // an edit key on an empty line changes nothing
        if (step_out.size() != 0 || len_was != 0 || line_len != 0) counted_items++;
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap_left = $urandom_range(1, 2);
                6, 7, 8:          gap_left = $urandom_range(3, 10);
                default:          gap_left = $urandom_range(20, 40);
            endcase
        end
    endtask

    task automatic wait_line_idle();
        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        gap_left = 0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input tld_pkg::tld_reg_t idx, input logic [6:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            tld_pkg::REG_ERASE: erase_ch = v;
            tld_pkg::REG_KILL:  kill_ch = v;
            tld_pkg::REG_INTR:  intr_ch = v;
            tld_pkg::REG_QUIT:  quit_ch = v;
            tld_pkg::REG_RAW:   raw_on = v[0];
            tld_pkg::REG_LCASE: lcase_on = v[0];
            tld_pkg::REG_CRNL:  crnl_on = v[0];
            tld_pkg::REG_FLOW:  flow_on = v[0];
            default: ;
        endcase
    endtask

    task automatic set_modes(input int p);
        logic [6:0] v [8];
        case (p)
            0: v = '{7'd0, 7'd127, 7'd3, 7'd28, 7'd0, 7'd0, 7'd1, 7'd1};
            1: v = '{7'd127, 7'd0, 7'd3, 7'd3, 7'd0, 7'd1, 7'd0, 7'd0};
            2: v = '{7'd35, 7'd64, 7'd127, 7'd28, 7'd1, 7'd1, 7'd1, 7'd1};
            3: v = '{7'd35, 7'd64, 7'd127, 7'd28, 7'd0, 7'd1, 7'd1, 7'd1};
            default: begin
                for (int i = 0; i < 4; i++) begin
                    case ($urandom_range(0, 5))
                        0: v[i] = 7'd8;
                        1: v[i] = 7'd21;
                        2: v[i] = 7'd3;
                        default: v[i] = 7'($urandom_range(0, 127));
                    endcase
                end
                v[4] = 7'($urandom_range(0, 3) == 0);
                for (int i = 5; i < 8; i++) v[i] = 7'($urandom_range(0, 1));
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(tld_pkg::tld_reg_t'(i), v[i]);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: c = 8'($urandom_range(32, 126));
            5, 6: c = {1'b0, tld_pkg::CH_BSL};
            7: begin
                case ($urandom_range(0, 8))
                    0: c = 8'd4;
                    1: c = 8'd33;
                    2: c = 8'd35;
                    3: c = 8'd39;
                    4: c = 8'd40;
                    5: c = 8'd41;
                    6: c = 8'd64;
                    7: c = 8'd94;
                    default: c = 8'($urandom_range(97, 122));
                endcase
            end
            8: c = {1'b0, erase_ch};
            9: c = {1'b0, kill_ch};
            default: c = 8'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 3) == 0) c[7] = 1'b1;
        return c;
    endfunction

    // printable, never an edit, signal or escape key, so a long line really fills
    function automatic logic [7:0] plain_char();
        logic [6:0] c;
        do c = 7'($urandom_range(32, 126));
        while (c == erase_ch || c == kill_ch || c == intr_ch || c == quit_ch
               || c == tld_pkg::CH_BSL || (c >= tld_pkg::CH_UC_A && c <= tld_pkg::CH_UC_Z));
        return {1'($urandom_range(0, 1)), c};
    endfunction

    function automatic logic [7:0] line_end();
        case ($urandom_range(0, 3))
            0: return {1'b0, tld_pkg::CH_NL};
            1: return {1'b0, tld_pkg::CH_CR};
            2: return {1'b0, tld_pkg::CH_EOT};
            default: return {1'b1, tld_pkg::CH_NL};
        endcase
    endfunction

    task automatic random_line();
        int pick;
        logic [6:0] key;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            repeat ($urandom_range(0, 10)) send_char(text_char());
            send_char(line_end());
        end else if (pick < 13) begin
            repeat ($urandom_range(62, 65)) send_char(plain_char());
            send_char(line_end());
        end else if (pick < 16) begin
            case ($urandom_range(0, 5))
                0: key = intr_ch;
                1: key = quit_ch;
                2: key = tld_pkg::CH_XOFF;
                3: key = tld_pkg::CH_XON;
                4: key = erase_ch;
                default: key = kill_ch;
            endcase
            send_char({1'($urandom_range(0, 1)), key});
        end else begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 39) == 0) wait_line_idle();
    endtask

    // receiver: m_ready walks an eight-bit stall pattern that is reloaded with a new random choice
    always @(posedge aclk) begin
        ready_step <= ready_step + 1;
        if (ready_step % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat <= 8'hFF;
                1: stall_pat <= 8'h01 << $urandom_range(0, 7);
                default: stall_pat <= 8'($urandom_range(1, 255));
            endcase
        end
        m_ready <= stall_pat[ready_step % 8];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing due: event_res %0d data_char %0d",
                       m_event_res, m_data_char);
                fail_count++;
            end else begin
                head = results_due.pop_front();
                if (m_event_res !== head.ev) begin
                    $error("event_res: expected %0d, got %0d", head.ev, m_event_res);
                    fail_count++;
                end
                if (m_data_char !== head.data) begin
                    $error("data_char: expected %0d, got %0d", head.data, m_data_char);
                    fail_count++;
                end
                if (m_last_of_run !== head.last) begin
                    $error("last_of_run: expected %0d, got %0d", head.last, m_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // reset modes: erase '#', kill '@', interrupt 127, quit 28, cooked, CR to NL
        plan_known(8'hFF, tld_pkg::EV_INT, 7'd0);
        plan_known(8'h9C, tld_pkg::EV_QUIT, 7'd0);
        plan_known(8'h04, tld_pkg::EV_EOF, 7'd0);
        plan_char("#");
        plan_char("a");
        plan_char("#");
        plan_char("\\");
        plan_char("#");
        plan_char("@");
        plan_char("\\");
        plan_char("\\");
        plan_char("@");
        plan_char(8'h8D);
        plan_char("\\");
        plan_known(8'h04, tld_pkg::EV_LINE, 7'd4);
        plan_known(8'h0A, tld_pkg::EV_LINE, 7'd10);
        plan_char(8'h80);
        plan_char(8'h8A);
        plan_reg(tld_pkg::REG_FLOW, 7'd1);
        plan_reg(tld_pkg::REG_LCASE, 7'd1);
        plan_reg(tld_pkg::REG_CRNL, 7'd0);
        plan_known(8'h13, tld_pkg::EV_STOP, 7'd0);
        plan_known(8'h91, tld_pkg::EV_RESUME, 7'd0);
        plan_char("\\");
        plan_char(8'hA8);
        plan_char("Q");
        plan_char(8'h0D);
        plan_char(8'h04);
        plan_reg(tld_pkg::REG_QUIT, 7'd127);
        plan_reg(tld_pkg::REG_RAW, 7'd1);
        plan_known("A", tld_pkg::EV_LINE, 7'd97);
        plan_known(8'hFF, tld_pkg::EV_LINE, 7'd127);
        plan_reg(tld_pkg::REG_RAW, 7'd0);
        plan_known(8'h7F, tld_pkg::EV_INT, 7'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                wait_line_idle();
                write_reg(plan[i].idx, plan[i].value[6:0]);
            end else begin
                send_char(plan[i].value, plan[i].known, plan[i].ev, plan[i].data);
            end
        end

        counted_items = 0;
        for (int p = 0; p < MODE_SETS; p++) begin
            wait_line_idle();
            set_modes(p);
            while (counted_items < (p + 1) * ITEMS_PER_MODE) random_line();
        end

        wait_line_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
src/tld_pkg.sv
src/tld_ctrl.sv
src/tld_dp.sv
src/tty_line_discipline_editor.sv
tb/sv/tty_line_discipline_editor_test.sv
